// ===== rtl/led_fire_heat_effect_top_defines.svh =====
// Assertion macros for the fire-effect RTL
`ifndef LED_FIRE_HEAT_EFFECT_TOP_DEFINES_SVH
`define LED_FIRE_HEAT_EFFECT_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off while arst_n is low
`define LFHE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fire effect assertion failed");
// next-cycle implication
`define LFHE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fire effect assertion failed");
`else
`define LFHE_ASSERT_IMP(lbl, ante, cons)
`define LFHE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/lfhe_pkg.sv =====
// Types and constants of the fire-effect heat block
`timescale 1ns / 1ps
package lfhe_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register indexes (paddr[ADDR_W-1:2])
	localparam logic [ADDR_W-3:0] REG_SPARK_THRESHOLD = '0;

	localparam logic [7:0] SPARK_THRESHOLD_RESET = 8'd120;

	typedef enum logic {
		REQ_COOL  = 1'b0,
		REQ_FRAME = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SPARK,
		BK_EMIT
	} back_state_t;

	// classified command handed from the front to the back
	typedef struct packed {
		logic       frame;
		logic       spark;
		logic [4:0] cell_idx;
		logic [7:0] value;
	} cmd_t;

	// one heat read-out on its way to the colour stage
	typedef struct packed {
		logic [7:0] heat;
		logic [4:0] index;
		logic       last;
	} beat_t;

endpackage

// ===== rtl/lfhe_ifs.sv =====
// Valid/ready channel interfaces for requests and pixel colours
`timescale 1ns / 1ps
interface lfhe_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [4:0] cell_index;
	logic [7:0] cooldown_amount;
	logic [7:0] spark_roll;
	logic [2:0] spark_cell;
	logic [7:0] spark_heat;

	modport source (
		output valid, req_type, cell_index, cooldown_amount, spark_roll, spark_cell,
			spark_heat,
		input  ready
	);
	modport sink (
		input  valid, req_type, cell_index, cooldown_amount, spark_roll, spark_cell,
			spark_heat,
		output ready
	);
endinterface

interface lfhe_pix_if;
	logic       valid;
	logic       ready;
	logic [4:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_pixel;

	modport source (
		output valid, pixel_index, red, green, blue, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_index, red, green, blue, last_pixel,
		output ready
	);
endinterface

// ===== rtl/led_fire_heat_effect_top.sv =====
// Fire-effect LED heat field: top level with APB register and channels
//
// Keeps one 8-bit heat value per LED. A cool request lowers one cell and
// gives no output; a frame-end request diffuses heat up the strip, maybe adds
// a spark, then streams NUM_LEDS colours in LED order with last_pixel on the
// final one. Requests pass a registered front stage and a two-entry command
// queue, so up to three can be taken while the back end is busy. In the back
// end a cool is applied as it is taken; a frame end diffuses the cells as
// it is taken, adds the spark in BK_SPARK when it fires, then reads the
// heat cells in BK_EMIT one per cycle while the colour stage accepts them,
// the single heat read port setting that rate. The colour stage and output
// register lie between read-out and pixel port. The spark threshold sits at
// byte address 0 and resets to 120; write it only while the block is idle.
`timescale 1ns / 1ps
module led_fire_heat_effect_top #(
	parameter int NUM_LEDS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lfhe_pkg::ADDR_W-1:0] paddr,
	input  logic [lfhe_pkg::DATA_W-1:0] pwdata,
	output logic [lfhe_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	lfhe_req_if.sink                    req,
	lfhe_pix_if.source                  pix
);
	import lfhe_pkg::*;

	logic [7:0] spark_threshold_q;
	logic       thr_sel;
	logic       front_valid;
	logic       front_ready;
	cmd_t       front_cmd;
	logic       fifo_valid;
	logic       fifo_ready;
	cmd_t       fifo_cmd;
	logic       beat_valid;
	logic       beat_ready;
	beat_t      beat;

	assign pready  = 1'b1;
	assign thr_sel = (paddr[ADDR_W-1:2] == REG_SPARK_THRESHOLD);
	assign prdata  = thr_sel ? DATA_W'(spark_threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spark_threshold_q <= SPARK_THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && thr_sel) begin
			spark_threshold_q <= pwdata[7:0];
		end
	end

	lfhe_front #(
		.NUM_LEDS (NUM_LEDS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.spark_threshold (spark_threshold_q),
		.cmd_valid       (front_valid),
		.cmd_ready       (front_ready),
		.cmd             (front_cmd)
	);

	lfhe_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (fifo_valid),
		.out_ready (fifo_ready),
		.out_cmd   (fifo_cmd)
	);

	lfhe_back #(
		.NUM_LEDS (NUM_LEDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (fifo_valid),
		.cmd_ready  (fifo_ready),
		.cmd        (fifo_cmd),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat)
	);

	lfhe_colour u_colour (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat),
		.pix        (pix)
	);

endmodule

// ===== rtl/lfhe_front.sv =====
// Front end: takes requests, classifies them and registers a command
`timescale 1ns / 1ps
module lfhe_front #(
	parameter int NUM_LEDS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	lfhe_req_if.sink       req,
	input  logic [7:0]     spark_threshold,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output lfhe_pkg::cmd_t cmd
);
	import lfhe_pkg::*;

	logic cmd_v_s1;
	cmd_t cmd_s1;
	cmd_t cmd_new;
	logic is_frame;
	logic cool_hit;
	logic spark_hit;

	always_comb begin
		is_frame  = (req.req_type == REQ_FRAME);
		cool_hit  = (32'(req.cell_index) < NUM_LEDS);
		spark_hit = (req.spark_roll < spark_threshold) && (32'(req.spark_cell) < NUM_LEDS);
		cmd_new.frame    = is_frame;
		cmd_new.spark    = is_frame && spark_hit;
		cmd_new.cell_idx = is_frame ? 5'(req.spark_cell) : req.cell_index;
		cmd_new.value    = is_frame ? req.spark_heat : req.cooldown_amount;
	end

	assign req.ready = !cmd_v_s1 || cmd_ready;

	// a cool aimed beyond the strip has no effect and is dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_s1 <= 1'b0;
		end else if (req.ready) begin
			cmd_v_s1 <= req.valid && (is_frame || cool_hit);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= cmd_new;
		end
	end

	assign cmd_valid = cmd_v_s1;
	assign cmd       = cmd_s1;

endmodule

// ===== rtl/lfhe_cmd_fifo.sv =====
// Two-entry command queue between front and back
`timescale 1ns / 1ps
module lfhe_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lfhe_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output lfhe_pkg::cmd_t out_cmd
);
	import lfhe_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

// ===== rtl/lfhe_back.sv =====
// Back end: heat cells, cool/diffuse/spark sequencer and read-out
`timescale 1ns / 1ps
`include "led_fire_heat_effect_top_defines.svh"
module lfhe_back #(
	parameter int NUM_LEDS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  lfhe_pkg::cmd_t  cmd,
	output logic            beat_valid,
	input  logic            beat_ready,
	output lfhe_pkg::beat_t beat
);
	import lfhe_pkg::*;

	localparam int CW = $clog2(NUM_LEDS);
	localparam logic [9:0] DIV3_RECIP = 10'd683;

	// floor(s/3) for s up to 765 by reciprocal multiply
	function automatic logic [7:0] div3(input logic [9:0] s);
		logic [19:0] p;
		p = s * DIV3_RECIP;
		return p[18:11];
	endfunction

	back_state_t state_q;
	back_state_t state_d;
	logic [7:0]  heat_q [NUM_LEDS];
	logic [7:0]  diff_heat [NUM_LEDS];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] spark_cell_q;
	logic [7:0]  spark_heat_q;
	logic [CW-1:0] rd_addr;
	logic [7:0]  rd_data;
	logic [7:0]  cool_val;
	logic        take;
	logic        issue;
	logic        last;

	for (genvar k = 0; k < NUM_LEDS; k++) begin : g_diff
		if (k < 2) begin : g_keep
			assign diff_heat[k] = heat_q[k];
		end else begin : g_mix
			assign diff_heat[k] = div3({2'b00, heat_q[k-1]} + {1'b0, heat_q[k-2], 1'b0});
		end
	end

	always_comb begin
		case (state_q)
			BK_SPARK: rd_addr = spark_cell_q;
			BK_EMIT:  rd_addr = cnt_q;
			default:  rd_addr = CW'(cmd.cell_idx);
		endcase
	end

	assign rd_data  = heat_q[rd_addr];
	assign cool_val = (cmd.value > rd_data) ? 8'd0 : (rd_data - cmd.value);
	assign last     = (cnt_q == CW'(NUM_LEDS - 1));
	assign take     = cmd_valid && cmd_ready;
	assign issue    = beat_valid && beat_ready;

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		beat_valid = 1'b0;
		case (state_q)
			BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && cmd.frame) begin
					state_d = cmd.spark ? BK_SPARK : BK_EMIT;
				end
			end
			BK_SPARK: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				beat_valid = 1'b1;
				if (beat_ready && last) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign beat.heat  = rd_data;
	assign beat.index = 5'(cnt_q);
	assign beat.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				cnt_q <= last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LEDS; k++) begin
				heat_q[k] <= 8'd0;
			end
		end else if (take) begin
			if (cmd.frame) begin
				for (int k = 0; k < NUM_LEDS; k++) begin
					heat_q[k] <= diff_heat[k];
				end
			end else begin
				heat_q[CW'(cmd.cell_idx)] <= cool_val;
			end
		end else if (state_q == BK_SPARK) begin
			// spark lands on the diffused value, wrapping
			heat_q[spark_cell_q] <= rd_data + spark_heat_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			spark_cell_q <= CW'(cmd.cell_idx);
			spark_heat_q <= cmd.value;
		end
	end

	`LFHE_ASSERT_NEXT(a_spark_then_emit, state_q == BK_SPARK, state_q == BK_EMIT && cnt_q == '0)
	`LFHE_ASSERT_NEXT(a_last_to_idle, issue && last, state_q == BK_IDLE && cnt_q == '0)
	`LFHE_ASSERT_IMP(a_cnt_range, state_q == BK_EMIT, cnt_q <= CW'(NUM_LEDS - 1))
	`LFHE_ASSERT_NEXT(a_emit_order, issue && !last, state_q == BK_EMIT && cnt_q == CW'($past(cnt_q) + 1'b1))

endmodule

// ===== rtl/lfhe_colour.sv =====
// Heat-to-colour ramp with a registered output stage
`timescale 1ns / 1ps
module lfhe_colour (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            beat_valid,
	output logic            beat_ready,
	input  lfhe_pkg::beat_t beat,
	lfhe_pix_if.source      pix
);
	import lfhe_pkg::*;

	localparam logic [15:0] HEAT_SCALE = 16'd191;
	localparam logic [15:0] SCALE_ROUND = 16'd127;
	localparam logic [7:0]  T_HIGH = 8'h80;
	localparam logic [7:0]  T_MID = 8'h40;
	localparam logic [7:0]  FULL = 8'd255;

	logic        beat_v_s1;
	beat_t       beat_s1;
	logic        out_v_q;
	logic [4:0]  index_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic        last_q;
	logic        out_adv;
	logic [15:0] scaled;
	logic [16:0] quot_sum;
	logic [7:0]  t;
	logic [7:0]  ramp;
	logic [7:0]  red_d;
	logic [7:0]  green_d;
	logic [7:0]  blue_d;

	// t = (h*191 + 127) / 255, the divide done as x + x/256 + 1 over 256
	always_comb begin
		scaled   = {8'd0, beat_s1.heat} * HEAT_SCALE + SCALE_ROUND;
		quot_sum = {1'b0, scaled} + 17'(scaled[15:8]) + 17'd1;
		t        = quot_sum[15:8];
		ramp     = {t[5:0], 2'b00};
		if (t > T_HIGH) begin
			red_d = FULL; green_d = FULL; blue_d = ramp;
		end else if (t > T_MID) begin
			red_d = FULL; green_d = ramp; blue_d = 8'd0;
		end else begin
			red_d = ramp; green_d = 8'd0; blue_d = 8'd0;
		end
	end

	assign out_adv    = !out_v_q || pix.ready;
	assign beat_ready = !beat_v_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (beat_ready) begin
				beat_v_s1 <= beat_valid;
			end
			if (out_adv) begin
				out_v_q <= beat_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_valid && beat_ready) begin
			beat_s1 <= beat;
		end
		if (out_adv && beat_v_s1) begin
			index_q <= beat_s1.index;
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			last_q  <= beat_s1.last;
		end
	end

	assign pix.valid       = out_v_q;
	assign pix.pixel_index = index_q;
	assign pix.red         = red_q;
	assign pix.green       = green_q;
	assign pix.blue        = blue_q;
	assign pix.last_pixel  = last_q;

endmodule
